// ===== rtl/core/ola_pkg.sv =====
// Shared types, constants and saturation helpers for the obstacle lane assignment block.
package ola_pkg;

  localparam int POS_W       = 32;   // Q16.16 positions
  localparam int WID_W       = 24;   // Q8.16 obstacle width
  localparam int COEF_W      = 48;   // Q16.32 line coefficients
  localparam int LO_W        = 32;   // low part of a coefficient in the split multiply
  localparam int FRAC_SHIFT  = 16;   // product rescale, Q16.32 * Q16.16 -> Q16.32
  localparam int SUM_W       = 66;   // Horner step sum before saturation
  localparam int F_W         = 52;   // doubled offset and its width-adjusted copies
  localparam int D_W         = 54;   // lane decision compare width
  localparam int OFF_SHIFT   = 17;   // doubled Q16.32 -> Q16.16
  localparam int OFF_W       = 33;   // centre offset output
  localparam int SHR_W       = F_W - OFF_SHIFT;
  localparam int CIDX_W      = 4;
  localparam int Q_DEPTH_DEF = 16;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t LEFT_OFFSET_RST  = -48'sd7516192768;   // -1.75 m
  localparam coef_t RIGHT_OFFSET_RST = 48'sd7516192768;    // +1.75 m

  // twice the 0.5 m overlap margin, Q16.32
  localparam logic signed [D_W-1:0] MARGIN = 54'sd4294967296;

  typedef enum logic [CIDX_W-1:0] {
    REG_LEFT_OFFSET     = 4'd0,
    REG_LEFT_SLOPE      = 4'd1,
    REG_LEFT_CURV       = 4'd2,
    REG_LEFT_CURV_RATE  = 4'd3,
    REG_RIGHT_OFFSET    = 4'd4,
    REG_RIGHT_SLOPE     = 4'd5,
    REG_RIGHT_CURV      = 4'd6,
    REG_RIGHT_CURV_RATE = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    LANE_NONE         = 3'd0,
    LANE_LEFT         = 3'd1,
    LANE_LEFT_CENTRE  = 3'd2,
    LANE_CENTRE       = 3'd3,
    LANE_CENTRE_RIGHT = 3'd4,
    LANE_RIGHT        = 3'd5,
    LANE_ALL          = 3'd6
  } lane_code_t;

  typedef struct packed {
    coef_t left_offset;
    coef_t left_slope;
    coef_t left_curv;
    coef_t left_curv_rate;
    coef_t right_offset;
    coef_t right_slope;
    coef_t right_curv;
    coef_t right_curv_rate;
  } ola_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] lat;
    logic [WID_W-1:0]        wid;
    logic                    away;
  } ola_item_t;

  typedef struct packed {
    logic signed [F_W-1:0] f2;
    logic signed [F_W-1:0] fpv;
    logic signed [F_W-1:0] fmv;
    logic                  away;
  } ola_mid_t;

  function automatic coef_t sat48(input logic signed [SUM_W-1:0] x);
    if (x[SUM_W-1:COEF_W-1] == {(SUM_W-COEF_W+1){x[SUM_W-1]}}) begin
      return x[COEF_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COEF_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OFF_W-1:0] sat33(input logic signed [SHR_W-1:0] x);
    if (x[SHR_W-1:OFF_W-1] == {(SHR_W-OFF_W+1){x[SHR_W-1]}}) begin
      return x[OFF_W-1:0];
    end else if (x[SHR_W-1]) begin
      return {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OFF_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/core/ola_in_if.sv =====
// Obstacle input channel: valid/ready plus one obstacle word.
interface ola_in_if;
  import ola_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] obstacle_long;
  logic signed [POS_W-1:0] obstacle_lat;
  logic [WID_W-1:0]        obstacle_width;

  modport source (output valid, output obstacle_long, output obstacle_lat,
                  output obstacle_width, input ready);
  modport sink (input valid, input obstacle_long, input obstacle_lat,
                input obstacle_width, output ready);
endinterface

// ===== rtl/core/ola_out_if.sv =====
// Result channel: valid/ready plus lane code and centre offset.
interface ola_out_if;
  import ola_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              lane_code;
  logic signed [OFF_W-1:0] centre_offset;

  modport source (output valid, output lane_code, output centre_offset, input ready);
  modport sink (input valid, input lane_code, input centre_offset, output ready);
endinterface

// ===== rtl/core/ola_cfg_if.sv =====
// Configuration write channel: valid/ready plus register index and data.
interface ola_cfg_if;
  import ola_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  coef_t             data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ola_regs.sv =====
// Lane-line coefficient registers written over the configuration channel.
module ola_regs (
  input  logic              clk,
  input  logic              rst_n,
  ola_cfg_if.sink           cfg_if,
  output ola_pkg::ola_cfg_t cfg
);
  import ola_pkg::*;

  ola_cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_offset     <= LEFT_OFFSET_RST;
      cfg_r.left_slope      <= '0;
      cfg_r.left_curv       <= '0;
      cfg_r.left_curv_rate  <= '0;
      cfg_r.right_offset    <= RIGHT_OFFSET_RST;
      cfg_r.right_slope     <= '0;
      cfg_r.right_curv      <= '0;
      cfg_r.right_curv_rate <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_LEFT_OFFSET:     cfg_r.left_offset     <= cfg_if.data;
        REG_LEFT_SLOPE:      cfg_r.left_slope      <= cfg_if.data;
        REG_LEFT_CURV:       cfg_r.left_curv       <= cfg_if.data;
        REG_LEFT_CURV_RATE:  cfg_r.left_curv_rate  <= cfg_if.data;
        REG_RIGHT_OFFSET:    cfg_r.right_offset    <= cfg_if.data;
        REG_RIGHT_SLOPE:     cfg_r.right_slope     <= cfg_if.data;
        REG_RIGHT_CURV:      cfg_r.right_curv      <= cfg_if.data;
        REG_RIGHT_CURV_RATE: cfg_r.right_curv_rate <= cfg_if.data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

// ===== rtl/core/ola_front.sv =====
// Front pipeline: accepts obstacles, evaluates both lane cubics and forms the doubled offset.
module ola_front #(
  parameter int Q_DEPTH = ola_pkg::Q_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ola_in_if.sink            in_if,
  input  ola_pkg::ola_cfg_t cfg,
  input  logic              pop,
  output logic              push,
  output ola_pkg::ola_mid_t push_data
);
  import ola_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam int NSTG  = 7;                          // input stage plus three mul/add pairs
  localparam int PH_W  = COEF_W - LO_W + POS_W;
  localparam int PL_W  = LO_W + 1 + POS_W;
  localparam int HI_SH = LO_W - FRAC_SHIFT;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    accept;
  coef_t                   coef [2][4];
  logic [NSTG-1:0]         vld_r;
  ola_item_t               item_r [NSTG];
  coef_t                   p_r [2][3];
  logic signed [PH_W-1:0]  ph_r [2][3];
  logic signed [PL_W-1:0]  pl_r [2][3];
  logic                    vld7_r;
  logic signed [F_W-1:0]   f2_r;
  logic [WID_W-1:0]        wid7_r;
  logic                    away7_r;
  logic                    push_r;
  ola_mid_t                mid_r;
  logic signed [F_W-1:0]   vext;

  assign coef[0][0] = cfg.left_offset;
  assign coef[0][1] = cfg.left_slope;
  assign coef[0][2] = cfg.left_curv;
  assign coef[0][3] = cfg.left_curv_rate;
  assign coef[1][0] = cfg.right_offset;
  assign coef[1][1] = cfg.right_slope;
  assign coef[1][2] = cfg.right_curv;
  assign coef[1][3] = cfg.right_curv_rate;

  // credits cover the pipeline and the queue, so the queue never overflows
  assign in_if.ready = (cnt_r < CNT_W'(Q_DEPTH));
  assign accept      = in_if.valid && in_if.ready;
  assign cnt_nxt     = cnt_r + CNT_W'(accept) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      vld_r  <= '0;
      vld7_r <= 1'b0;
      push_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      vld_r  <= {vld_r[NSTG-2:0], accept};
      vld7_r <= vld_r[NSTG-1];
      push_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r[0].z    <= in_if.obstacle_long;
    item_r[0].lat  <= in_if.obstacle_lat;
    item_r[0].wid  <= in_if.obstacle_width;
    item_r[0].away <= (in_if.obstacle_long != '0) || (in_if.obstacle_lat != '0);
    for (int s = 1; s < NSTG; s++) begin
      item_r[s] <= item_r[s-1];
    end
  end

  // Horner steps: multiply stage splits the 48-bit term into a 16-bit high and a 32-bit low part,
  // add stage recombines, adds the next coefficient and saturates
  for (genvar l = 0; l < 2; l++) begin : g_line
    for (genvar j = 0; j < 3; j++) begin : g_step
      coef_t                   p_src;
      logic signed [SUM_W-1:0] sum;

      if (j == 0) begin : g_first
        assign p_src = coef[l][3];
      end else begin : g_next
        assign p_src = p_r[l][j-1];
      end

      assign sum = SUM_W'($signed({ph_r[l][j], {HI_SH{1'b0}}}))
                 + SUM_W'(pl_r[l][j] >>> FRAC_SHIFT)
                 + SUM_W'(coef[l][2-j]);

      always_ff @(posedge clk) begin
        ph_r[l][j] <= $signed(p_src[COEF_W-1:LO_W]) * item_r[2*j].z;
        pl_r[l][j] <= $signed({1'b0, p_src[LO_W-1:0]}) * item_r[2*j].z;
        p_r[l][j]  <= sat48(sum);
      end
    end
  end

  assign vext = $signed(F_W'({wid7_r, {FRAC_SHIFT{1'b0}}}));

  always_ff @(posedge clk) begin
    f2_r       <= F_W'($signed({item_r[NSTG-1].lat, {(FRAC_SHIFT + 1){1'b0}}}))
                - F_W'(p_r[0][2]) - F_W'(p_r[1][2]);
    wid7_r     <= item_r[NSTG-1].wid;
    away7_r    <= item_r[NSTG-1].away;
    mid_r.f2   <= f2_r;
    mid_r.fpv  <= f2_r + vext;
    mid_r.fmv  <= f2_r - vext;
    mid_r.away <= away7_r;
  end

  assign push      = push_r;
  assign push_data = mid_r;

endmodule

// ===== rtl/core/ola_fifo.sv =====
// Queue between the front pipeline and the decision stage.
module ola_fifo #(
  parameter int DEPTH = ola_pkg::Q_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ola_pkg::ola_mid_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output ola_pkg::ola_mid_t head_data
);
  import ola_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ola_mid_t        mem [DEPTH];
  ola_mid_t        head_r;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   rd_addr;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  assign rd_addr    = pop ? rd_ptr_nxt : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    // forward a word written into the slot that becomes the head
    if (push && (wr_ptr_r == rd_addr)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem[rd_addr];
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = head_r;

endmodule

// ===== rtl/core/ola_back.sv =====
// Back end: lane decision, centre offset rounding and the output register.
module ola_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ola_pkg::ola_cfg_t cfg,
  input  logic              head_valid,
  input  ola_pkg::ola_mid_t head_data,
  output logic              pop,
  ola_out_if.source         out_if
);
  import ola_pkg::*;

  logic signed [D_W-1:0]   d;
  logic signed [D_W-1:0]   w_r, w3_r;
  logic signed [D_W-1:0]   f2, fpv, fmv;
  lane_code_t              code;
  logic signed [OFF_W-1:0] off;
  logic                    out_valid_r, out_valid_nxt;
  lane_code_t              code_r;
  logic signed [OFF_W-1:0] off_r;

  // lane width terms follow the registers; they settle well before the next word arrives
  assign d = D_W'(cfg.right_offset) - D_W'(cfg.left_offset);

  always_ff @(posedge clk) begin
    w_r  <= d[D_W-1] ? -d : d;
    w3_r <= w_r + (w_r <<< 1);
  end

  assign f2  = D_W'(head_data.f2);
  assign fpv = D_W'(head_data.fpv);
  assign fmv = D_W'(head_data.fmv);

  always_comb begin
    code = LANE_NONE;
    if (fpv < -w3_r || fmv > w3_r) begin
      code = LANE_NONE;
    end else if (f2 >= -w_r && f2 <= w_r && head_data.away) begin
      code = LANE_CENTRE;
      if (fpv > w_r + MARGIN) begin
        code = LANE_CENTRE_RIGHT;
        if (fmv < -w_r - MARGIN) begin
          code = LANE_ALL;
        end
      end
    end else if (f2 >= -w3_r && f2 <= -w_r) begin
      code = LANE_LEFT;
      if (fpv > -w_r + MARGIN) begin
        code = LANE_LEFT_CENTRE;
        if (fpv > w_r + MARGIN) begin
          code = LANE_ALL;
        end
      end
    end else if (f2 >= w_r && f2 <= w3_r) begin
      code = LANE_RIGHT;
      if (fmv < w_r - MARGIN) begin
        code = LANE_CENTRE_RIGHT;
        if (fmv < -w_r - MARGIN) begin
          code = LANE_ALL;
        end
      end
    end
  end

  // arithmetic shift gives the floor of the halved offset
  assign off = sat33(head_data.f2[F_W-1:OFF_SHIFT]);

  assign pop = head_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r <= code;
      off_r  <= off;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.lane_code     = code_r;
  assign out_if.centre_offset = off_r;

endmodule

// ===== rtl/core/obstacle_lane_assignment.sv =====
// Top level of the obstacle lane assignment block.
// One obstacle word is taken per clock while in_if.ready is high, and one result word
// comes out for each, in order. The rate is set by a fully pipelined front end: each of
// the three Horner steps of both lane cubics uses a multiply stage (48x32 split into
// 16x32 and 33x32 partial products) and an add/saturate stage, followed by the
// doubled-offset and width-adjust stages. A queue of Q_DEPTH words decouples it from
// the decision stage and output register; in_if.ready drops only while Q_DEPTH words
// sit between acceptance and the queue head. Configuration writes are taken one per
// cycle (cfg_if.ready is always high) and must land while no word is in flight.
module obstacle_lane_assignment #(
  parameter int Q_DEPTH = ola_pkg::Q_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ola_in_if.sink    in_if,
  ola_out_if.source out_if,
  ola_cfg_if.sink   cfg_if
);
  import ola_pkg::*;

  ola_cfg_t cfg;
  logic     push, pop, head_valid;
  ola_mid_t push_data, head_data;

  ola_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  ola_front #(.Q_DEPTH(Q_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  ola_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ola_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule

// ===== rtl/core/ola_checker.sv =====
// Port-level checks for the obstacle lane assignment block, bound to the top level.
module ola_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_lane_code,
  input logic signed [ola_pkg::OFF_W-1:0] out_centre_offset
);
  import ola_pkg::*;

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lane_code) && $stable(out_centre_offset))
    else $error("result word changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lane_code <= 3'(LANE_ALL))
    else $error("lane code out of range");

endmodule

bind obstacle_lane_assignment ola_checker u_ola_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_lane_code     (out_if.lane_code),
  .out_centre_offset (out_if.centre_offset)
);

// ===== bench/ola_lane_checker.sv =====
// Scoreboard for the obstacle lane assignment block: mirrors the lane lines and checks each word.
module ola_lane_checker
  import ola_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ola_in_if    in_w,
  ola_out_if   out_w,
  ola_cfg_if   cfg_w,
  output int   mismatch_count,
  output int   pending_words
);

  localparam int NUM_LINE_REGS = int'(REG_RIGHT_CURV_RATE) + 1;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [2:0]              code;
    logic signed [OFF_W-1:0] offset;
  } lane_word_t;

  localparam wide_t LINE_MAX = 128'sd140737488355327;
  localparam wide_t LINE_MIN = -128'sd140737488355328;
  localparam wide_t OFFSET_MAX = 128'sd4294967295;
  localparam wide_t OFFSET_MIN = -128'sd4294967296;

  coef_t      line_coef [NUM_LINE_REGS];
  lane_word_t expected_words [$];

  // Horner evaluation of one lane cubic, saturating after every step
  function automatic wide_t line_at(int base, wide_t z);
    wide_t acc;
    wide_t sum;
    int    k;
    acc = line_coef[base + 3];
    for (k = 2; k >= 0; k--) begin
      sum = ((acc * z) >>> FRAC_SHIFT) + line_coef[base + k];
      acc = (sum > LINE_MAX) ? LINE_MAX : ((sum < LINE_MIN) ? LINE_MIN : sum);
    end
    return acc;
  endfunction

  function automatic lane_word_t predict_lane(logic signed [POS_W-1:0] z_in,
                                              logic signed [POS_W-1:0] lat_in,
                                              logic [WID_W-1:0] wid_in);
    wide_t      zl, xl, v, f2, d, w, w3, m, off;
    logic       away;
    lane_code_t code;
    lane_word_t res;
    zl = z_in;
    xl = lat_in;
    v = wid_in;
    v = v <<< FRAC_SHIFT;
    m = MARGIN;
    f2 = (xl <<< (FRAC_SHIFT + 1)) - line_at(int'(REG_LEFT_OFFSET), zl)
         - line_at(int'(REG_RIGHT_OFFSET), zl);
    d = wide_t'(line_coef[REG_RIGHT_OFFSET]) - wide_t'(line_coef[REG_LEFT_OFFSET]);
    w = (d < 0) ? -d : d;
    w3 = 3 * w;
    away = (zl != 0) || (xl != 0);
    code = LANE_NONE;
    // all tests run on doubled offsets so the half widths stay exact
    if (f2 + v < -w3 || f2 - v > w3) begin
      code = LANE_NONE;
    end else if (f2 >= -w && f2 <= w && away) begin
      code = LANE_CENTRE;
      if (f2 + v > w + m) begin
        code = LANE_CENTRE_RIGHT;
        if (f2 - v < -w - m) code = LANE_ALL;
      end
    end else if (f2 >= -w3 && f2 <= -w) begin
      code = LANE_LEFT;
      if (f2 + v > -w + m) begin
        code = LANE_LEFT_CENTRE;
        if (f2 + v > w + m) code = LANE_ALL;
      end
    end else if (f2 >= w && f2 <= w3) begin
      code = LANE_RIGHT;
      if (f2 - v < w - m) begin
        code = LANE_CENTRE_RIGHT;
        if (f2 - v < -w - m) code = LANE_ALL;
      end
    end
    off = f2 >>> OFF_SHIFT;
    off = (off > OFFSET_MAX) ? OFFSET_MAX : ((off < OFFSET_MIN) ? OFFSET_MIN : off);
    res.code = code;
    res.offset = off[OFF_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    lane_word_t got;
    lane_word_t want;
    if (!rst_n) begin
      foreach (line_coef[i]) line_coef[i] = '0;
      line_coef[REG_LEFT_OFFSET] = LEFT_OFFSET_RST;
      line_coef[REG_RIGHT_OFFSET] = RIGHT_OFFSET_RST;
      expected_words.delete();
    end else begin
      if (out_w.valid && out_w.ready) begin
        got.code = out_w.lane_code;
        got.offset = out_w.centre_offset;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, none expected, got lane_code %0d centre_offset %0d",
                   $time, got.code, got.offset);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.code !== want.code) begin
            $display("%0t: lane_code expected %0d got %0d", $time, want.code, got.code);
            mismatch_count++;
          end
          if (got.offset !== want.offset) begin
            $display("%0t: centre_offset expected %0d got %0d", $time, want.offset, got.offset);
            mismatch_count++;
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        expected_words.push_back(predict_lane(in_w.obstacle_long, in_w.obstacle_lat,
                                              in_w.obstacle_width));
      end
      // drop writes to indexes past the last line register
      if (cfg_w.valid && cfg_w.ready && int'(cfg_w.index) < NUM_LINE_REGS) begin
        line_coef[cfg_w.index] = cfg_w.data;
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== bench/obstacle_lane_assignment_test.sv =====
// Top of the obstacle lane assignment bench: clock, reset, stimulus, receiver stalls and verdict.
module obstacle_lane_assignment_test;
  import ola_pkg::*;

  localparam int NUM_LINE_REGS   = int'(REG_RIGHT_CURV_RATE) + 1;
  localparam int LAST_INDEX      = (1 << CIDX_W) - 1;
  localparam int Q16_ONE         = 65536;
  localparam int HALF_M          = Q16_ONE / 2;
  localparam int LANE_EDGE       = 114688;     // 1.75 m
  localparam int OUTER_EDGE      = 344064;     // 5.25 m
  localparam int POS_MAX         = 32'sh7fff_ffff;
  localparam int POS_MIN         = 32'sh8000_0000;
  localparam int WID_MAX         = 24'hff_ffff;
  localparam longint MM_Q32      = 4294967;    // 1 mm in Q16.32
  localparam coef_t COEF_MAX     = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN     = {1'b1, {(COEF_W-1){1'b0}}};
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int NUM_DIRECTED    = 22;
  localparam int TAIL_CYCLES     = 40;
  localparam int TIME_LIMIT      = 2000000;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_words;
  int   stall_pct = 0;
  int   gap_max = 0;
  coef_t next_lines [NUM_LINE_REGS];

  // directed words: origin, centre, left, right, outside, inclusive edges, field extremes
  int dir_z [NUM_DIRECTED] = '{0, 0, 0, 10*Q16_ONE, 10*Q16_ONE, Q16_ONE,
                               20*Q16_ONE, 20*Q16_ONE, 20*Q16_ONE, 5*Q16_ONE, 5*Q16_ONE,
                               5*Q16_ONE, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE, 0,
                               POS_MAX, POS_MIN, POS_MIN, POS_MAX};
  int dir_lat [NUM_DIRECTED] = '{0, 0, HALF_M, 0, Q16_ONE, HALF_M,
                                 -3*Q16_ONE, -3*Q16_ONE, -3*Q16_ONE, 3*Q16_ONE, 3*Q16_ONE,
                                 3*Q16_ONE, -6*Q16_ONE, 6*Q16_ONE, -LANE_EDGE, -OUTER_EDGE,
                                 OUTER_EDGE, LANE_EDGE, POS_MAX, POS_MIN, POS_MAX, POS_MIN};
  int dir_wid [NUM_DIRECTED] = '{0, WID_MAX, 0, 0, 3*Q16_ONE, 10*Q16_ONE,
                                 Q16_ONE, 4*Q16_ONE, 12*Q16_ONE, 0, 4*Q16_ONE,
                                 12*Q16_ONE, 0, 2*Q16_ONE, 0, 0, 0, 0,
                                 WID_MAX, 0, 1, WID_MAX};

  ola_in_if  in_w ();
  ola_out_if out_w ();
  ola_cfg_if cfg_w ();

  obstacle_lane_assignment u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_w),
    .out_if (out_w),
    .cfg_if (cfg_w)
  );

  ola_lane_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_w           (in_w),
    .out_w          (out_w),
    .cfg_w          (cfg_w),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random stall runs, rate set per phase
  initial begin
    int stall_left;
    stall_left = 0;
    out_w.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_w.ready <= 1'b0;
        stall_left--;
      end else if (int'($urandom_range(99, 0)) < stall_pct) begin
        out_w.ready <= 1'b0;
        stall_left = $urandom_range(5, 0);
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  function automatic longint spread(int unsigned r);
    return longint'($urandom_range(2 * r, 0)) - longint'(r);
  endfunction

  function automatic coef_t rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[COEF_W-1:0];
  endfunction

  function automatic int pick_pos(int span_m);
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) begin
      case ($urandom_range(4, 0))
        0: return POS_MIN;
        1: return POS_MAX;
        2: return 0;
        3: return 1;
        default: return -1;
      endcase
    end else if (sel == 1) begin
      return $urandom;
    end
    return int'($urandom_range(2 * span_m * Q16_ONE, 0)) - span_m * Q16_ONE;
  endfunction

  function automatic int pick_width();
    int sel;
    logic [31:0] r;
    sel = $urandom_range(9, 0);
    r = $urandom;
    if (sel == 0) begin
      case ($urandom_range(2, 0))
        0: return 0;
        1: return 1;
        default: return WID_MAX;
      endcase
    end else if (sel == 1) begin
      return int'(r[WID_W-1:0]);
    end
    return $urandom_range(6 * Q16_ONE, 0);
  endfunction

  // hold valid high after the word is taken; the caller lowers it
  task automatic send_obstacle(int z, int lat, int wid);
    in_w.valid <= 1'b1;
    in_w.obstacle_long <= z;
    in_w.obstacle_lat <= lat;
    in_w.obstacle_width <= wid[WID_W-1:0];
    do @(posedge clk); while (!in_w.ready);
  endtask

  task automatic run_random_items(int count);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      while (burst > 0 && left > 0) begin
        send_obstacle(pick_pos(120), pick_pos(8), pick_width());
        burst--;
        left--;
      end
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_w.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_words != 0);
  endtask

  // write all line registers, then one spare index that must be ignored
  task automatic load_lines();
    int i;
    for (i = 0; i < NUM_LINE_REGS; i++) begin
      cfg_w.valid <= 1'b1;
      cfg_w.index <= reg_idx_t'(i);
      cfg_w.data <= next_lines[i];
      do @(posedge clk); while (!cfg_w.ready);
    end
    cfg_w.valid <= 1'b1;
    cfg_w.index <= CIDX_W'($urandom_range(LAST_INDEX, NUM_LINE_REGS));
    cfg_w.data <= rand_coef();
    do @(posedge clk); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
  endtask

  task automatic fill_realistic(bit swapped);
    longint lo, ro;
    lo = -(longint'($urandom_range(2200, 1300)) * MM_Q32);
    ro = longint'($urandom_range(2200, 1300)) * MM_Q32;
    next_lines[REG_LEFT_OFFSET]     = coef_t'(swapped ? ro : lo);
    next_lines[REG_RIGHT_OFFSET]    = coef_t'(swapped ? lo : ro);
    next_lines[REG_LEFT_SLOPE]      = coef_t'(spread(214748365));
    next_lines[REG_RIGHT_SLOPE]     = coef_t'(spread(214748365));
    next_lines[REG_LEFT_CURV]       = coef_t'(spread(8589935));
    next_lines[REG_RIGHT_CURV]      = coef_t'(spread(8589935));
    next_lines[REG_LEFT_CURV_RATE]  = coef_t'(spread(85899));
    next_lines[REG_RIGHT_CURV_RATE] = coef_t'(spread(85899));
  endtask

  initial begin
    int i, phase;
    rst_n = 1'b0;
    in_w.valid = 1'b0;
    in_w.obstacle_long = '0;
    in_w.obstacle_lat = '0;
    in_w.obstacle_width = '0;
    cfg_w.valid = 1'b0;
    cfg_w.index = '0;
    cfg_w.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) send_obstacle(dir_z[i], dir_lat[i], dir_wid[i]);
    in_w.valid <= 1'b0;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      if (phase != 0) begin
        case (phase)
          3: fill_realistic(1'b1);
          4: begin
            fill_realistic(1'b0);
            next_lines[REG_RIGHT_OFFSET] = next_lines[REG_LEFT_OFFSET];
          end
          5: foreach (next_lines[k]) next_lines[k] = COEF_MAX;
          6: foreach (next_lines[k]) next_lines[k] = COEF_MIN;
          7: foreach (next_lines[k]) next_lines[k] = (k < int'(REG_RIGHT_OFFSET)) ?
                                                      COEF_MIN : COEF_MAX;
          8, 10: foreach (next_lines[k]) next_lines[k] = rand_coef();
          11: foreach (next_lines[k]) next_lines[k] = '0;
          default: fill_realistic(1'b0);
        endcase
        load_lines();
      end
      // rotate between no idling, light idling and heavy idling
      case (phase % 3)
        0: begin
          gap_max = 0;
          stall_pct = 0;
        end
        1: begin
          gap_max = 3;
          stall_pct = 25;
        end
        default: begin
          gap_max = 10;
          stall_pct = 60;
        end
      endcase
      run_random_items(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("obstacle_lane_assignment test passed");
    end else begin
      $display("obstacle_lane_assignment test failed");
    end
    $finish;
  end

  initial begin
    #TIME_LIMIT;
    $display("obstacle_lane_assignment test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ola_pkg.sv
rtl/core/ola_in_if.sv
rtl/core/ola_out_if.sv
rtl/core/ola_cfg_if.sv
rtl/core/ola_regs.sv
rtl/core/ola_front.sv
rtl/core/ola_fifo.sv
rtl/core/ola_back.sv
rtl/core/obstacle_lane_assignment.sv
rtl/core/ola_checker.sv
bench/ola_lane_checker.sv
bench/obstacle_lane_assignment_test.sv
